FILE: hdl/link_rate_mode_selector_unit_defines.svh
// ----------------------------------------------------------------------------
// link_rate_mode_selector_unit_defines
// Assertion macros used by the checker file of the rate mode selector.
// ----------------------------------------------------------------------------
`ifndef LINK_RATE_MODE_SELECTOR_UNIT_DEFINES_SVH
`define LINK_RATE_MODE_SELECTOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LRMS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LRMS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lrms_pkg.sv
// ----------------------------------------------------------------------------
// lrms_pkg
// Widths, register map, level codes and the threshold function of the
// rate mode selector.
// ----------------------------------------------------------------------------
`default_nettype none

package lrms_pkg;

  localparam int RATE_W   = 23;
  localparam int KBPS_W   = 24;
  localparam int FRAC_W   = 8;
  localparam int SMOOTH_W = RATE_W + FRAC_W;
  localparam int DEPTH_W  = 16;
  localparam int HOLD_W   = 24;
  localparam int TIME_W   = 32;
  localparam int LEVEL_W  = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // EWMA weight in Q8, clamped to 1.0
  localparam int EWMA_ALPHA_Q8 = 64;
  localparam int ALPHA_INT     = (EWMA_ALPHA_Q8 > 256) ? 256 : EWMA_ALPHA_Q8;
  localparam int ALPHA_W       = FRAC_W + 1;
  localparam logic [ALPHA_W-1:0] ALPHA_Q8   = ALPHA_W'(ALPHA_INT);
  localparam logic [ALPHA_W-1:0] ALPHA_REST = ALPHA_W'(256 - ALPHA_INT);
  localparam int ACC_W = SMOOTH_W + ALPHA_W;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_MIN    = 3'd0,
    REG_DELTA_MIN   = 3'd1,
    REG_DYNAMIC_MIN = 3'd2,
    REG_UP_MARGIN   = 3'd3,
    REG_CONGESTED   = 3'd4,
    REG_UP_HOLD     = 3'd5,
    REG_DOWN_HOLD   = 3'd6,
    REG_MIN_DWELL   = 3'd7
  } reg_idx_t;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL    = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_DELTA   = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_DYNAMIC = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_META    = 2'd3;

  localparam logic [RATE_W-1:0]  RST_FULL_MIN    = RATE_W'(20000);
  localparam logic [RATE_W-1:0]  RST_DELTA_MIN   = RATE_W'(5000);
  localparam logic [RATE_W-1:0]  RST_DYNAMIC_MIN = RATE_W'(1000);
  localparam logic [RATE_W-1:0]  RST_UP_MARGIN   = RATE_W'(500);
  localparam logic [DEPTH_W-1:0] RST_CONGESTED   = DEPTH_W'(64);
  localparam logic [HOLD_W-1:0]  RST_UP_HOLD     = HOLD_W'(2000);
  localparam logic [HOLD_W-1:0]  RST_DOWN_HOLD   = HOLD_W'(500);
  localparam logic [HOLD_W-1:0]  RST_MIN_DWELL   = HOLD_W'(1000);

  typedef struct packed {
    logic [RATE_W-1:0]  full_min_kbps;
    logic [RATE_W-1:0]  delta_min_kbps;
    logic [RATE_W-1:0]  dynamic_min_kbps;
    logic [RATE_W-1:0]  up_margin_kbps;
    logic [DEPTH_W-1:0] congested_depth;
    logic [HOLD_W-1:0]  up_hold_ms;
    logic [HOLD_W-1:0]  down_hold_ms;
    logic [HOLD_W-1:0]  min_dwell_ms;
  } cfg_t;

  typedef struct packed {
    logic                first;
    logic [SMOOTH_W-1:0] rate;
  } rate_info_t;

  // integer part of the smoothed rate against thresholds plus margin
  function automatic logic [LEVEL_W-1:0] level_for(
    input logic [RATE_W-1:0] s_int,
    input cfg_t              c,
    input logic [RATE_W-1:0] margin
  );
    logic [RATE_W:0]      s_ext;
    logic [RATE_W:0]      t0;
    logic [RATE_W:0]      t1;
    logic [RATE_W:0]      t2;
    logic [LEVEL_W-1:0]   lvl;
    s_ext = {1'b0, s_int};
    t0 = {1'b0, c.full_min_kbps} + {1'b0, margin};
    t1 = {1'b0, c.delta_min_kbps} + {1'b0, margin};
    t2 = {1'b0, c.dynamic_min_kbps} + {1'b0, margin};
    if (s_ext >= t0) begin
      lvl = LEVEL_FULL;
    end else if (s_ext >= t1) begin
      lvl = LEVEL_DELTA;
    end else if (s_ext >= t2) begin
      lvl = LEVEL_DYNAMIC;
    end else begin
      lvl = LEVEL_META;
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/lrms_cfg_regs.sv
// ----------------------------------------------------------------------------
// lrms_cfg_regs
// Configuration register file; writes are masked to each register's width.
// ----------------------------------------------------------------------------
`default_nettype none

module lrms_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [lrms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lrms_pkg::CFG_DATA_W-1:0]  cfg_data,
  output      lrms_pkg::cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_min_kbps    <= lrms_pkg::RST_FULL_MIN;
      cfg.delta_min_kbps   <= lrms_pkg::RST_DELTA_MIN;
      cfg.dynamic_min_kbps <= lrms_pkg::RST_DYNAMIC_MIN;
      cfg.up_margin_kbps   <= lrms_pkg::RST_UP_MARGIN;
      cfg.congested_depth  <= lrms_pkg::RST_CONGESTED;
      cfg.up_hold_ms       <= lrms_pkg::RST_UP_HOLD;
      cfg.down_hold_ms     <= lrms_pkg::RST_DOWN_HOLD;
      cfg.min_dwell_ms     <= lrms_pkg::RST_MIN_DWELL;
    end else if (cfg_valid && cfg_ready) begin
      case (lrms_pkg::reg_idx_t'(cfg_index))
        lrms_pkg::REG_FULL_MIN:
          cfg.full_min_kbps <= cfg_data[lrms_pkg::RATE_W-1:0];
        lrms_pkg::REG_DELTA_MIN:
          cfg.delta_min_kbps <= cfg_data[lrms_pkg::RATE_W-1:0];
        lrms_pkg::REG_DYNAMIC_MIN:
          cfg.dynamic_min_kbps <= cfg_data[lrms_pkg::RATE_W-1:0];
        lrms_pkg::REG_UP_MARGIN:
          cfg.up_margin_kbps <= cfg_data[lrms_pkg::RATE_W-1:0];
        lrms_pkg::REG_CONGESTED:
          cfg.congested_depth <= cfg_data[lrms_pkg::DEPTH_W-1:0];
        lrms_pkg::REG_UP_HOLD:
          cfg.up_hold_ms <= cfg_data[lrms_pkg::HOLD_W-1:0];
        lrms_pkg::REG_DOWN_HOLD:
          cfg.down_hold_ms <= cfg_data[lrms_pkg::HOLD_W-1:0];
        lrms_pkg::REG_MIN_DWELL:
          cfg.min_dwell_ms <= cfg_data[lrms_pkg::HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lrms_rate_filter.sv
// ----------------------------------------------------------------------------
// lrms_rate_filter
// EWMA of the clamped bandwidth in Q23.8, seeded by the first sample.
// ----------------------------------------------------------------------------
`default_nettype none

module lrms_rate_filter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [lrms_pkg::RATE_W-1:0]   x,
  output      lrms_pkg::rate_info_t          info
);

  logic                              seeded;
  logic [lrms_pkg::SMOOTH_W-1:0]     smoothed_rate;
  logic [lrms_pkg::ACC_W-1:0]        acc;

  always_comb begin
    acc = lrms_pkg::ACC_W'(lrms_pkg::ALPHA_Q8)
            * lrms_pkg::ACC_W'({x, lrms_pkg::FRAC_W'(0)})
        + lrms_pkg::ACC_W'(lrms_pkg::ALPHA_REST)
            * lrms_pkg::ACC_W'(smoothed_rate)
        + lrms_pkg::ROUND_HALF;
    info.first = !seeded;
    if (!seeded) begin
      info.rate = {x, lrms_pkg::FRAC_W'(0)};
    end else begin
      info.rate = acc[lrms_pkg::SMOOTH_W+lrms_pkg::FRAC_W-1:lrms_pkg::FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded        <= 1'b0;
      smoothed_rate <= '0;
    end else if (step) begin
      seeded        <= 1'b1;
      smoothed_rate <= info.rate;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lrms_level_ctrl.sv
// ----------------------------------------------------------------------------
// lrms_level_ctrl
// Candidate level selection with hysteresis, congestion, hold and dwell.
// ----------------------------------------------------------------------------
`default_nettype none

module lrms_level_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [lrms_pkg::TIME_W-1:0]   now,
  input  wire logic [lrms_pkg::DEPTH_W-1:0]  depth,
  input  wire lrms_pkg::rate_info_t          info,
  input  wire lrms_pkg::cfg_t                cfg,
  output      logic [lrms_pkg::LEVEL_W-1:0]  level_next
);

  logic [lrms_pkg::LEVEL_W-1:0] current_level;
  logic [lrms_pkg::LEVEL_W-1:0] candidate_level;
  logic [lrms_pkg::TIME_W-1:0]  candidate_start;
  logic [lrms_pkg::TIME_W-1:0]  last_change_time;

  logic [lrms_pkg::LEVEL_W-1:0] candidate_level_next;
  logic [lrms_pkg::TIME_W-1:0]  candidate_start_next;
  logic [lrms_pkg::TIME_W-1:0]  last_change_time_next;

  logic [lrms_pkg::RATE_W-1:0]  s_int;
  logic [lrms_pkg::LEVEL_W-1:0] want_plain;
  logic [lrms_pkg::LEVEL_W-1:0] want_up;
  logic [lrms_pkg::LEVEL_W-1:0] want;
  logic [lrms_pkg::LEVEL_W-1:0] want_bumped;
  logic [lrms_pkg::TIME_W-1:0]  lct_eff;
  logic [lrms_pkg::TIME_W-1:0]  held;
  logic [lrms_pkg::TIME_W-1:0]  dwelt;
  logic [lrms_pkg::HOLD_W-1:0]  hold;

  always_comb begin
    s_int      = info.rate[lrms_pkg::SMOOTH_W-1:lrms_pkg::FRAC_W];
    want_plain = lrms_pkg::level_for(s_int, cfg, '0);
    want_up    = lrms_pkg::level_for(s_int, cfg, cfg.up_margin_kbps);
    want       = (want_plain < current_level) ? want_up : want_plain;
    want_bumped = want + lrms_pkg::LEVEL_W'(1);
    if (depth >= cfg.congested_depth && want != lrms_pkg::LEVEL_META) begin
      want = (want_bumped < current_level) ? current_level : want_bumped;
    end

    lct_eff = info.first ? now : last_change_time;
    held    = now - candidate_start;
    dwelt   = now - lct_eff;
    hold    = (want < current_level) ? cfg.up_hold_ms : cfg.down_hold_ms;

    level_next            = current_level;
    candidate_level_next  = candidate_level;
    candidate_start_next  = candidate_start;
    last_change_time_next = lct_eff;

    if (want == current_level) begin
      candidate_level_next = current_level;
      candidate_start_next = now;
    end else if (want != candidate_level) begin
      candidate_level_next = want;
      candidate_start_next = now;
    end else if (held >= lrms_pkg::TIME_W'(hold)
                 && dwelt >= lrms_pkg::TIME_W'(cfg.min_dwell_ms)) begin
      level_next            = want;
      last_change_time_next = now;
      candidate_start_next  = now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_level    <= lrms_pkg::LEVEL_META;
      candidate_level  <= lrms_pkg::LEVEL_META;
      candidate_start  <= '0;
      last_change_time <= '0;
    end else if (step) begin
      current_level    <= level_next;
      candidate_level  <= candidate_level_next;
      candidate_start  <= candidate_start_next;
      last_change_time <= last_change_time_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/link_rate_mode_selector_unit.sv
// ----------------------------------------------------------------------------
// link_rate_mode_selector_unit
// Picks a transmit level from bandwidth reports: EWMA smoothing, thresholds
// with upgrade margin, congestion degrade, hold and dwell timers.
// ----------------------------------------------------------------------------
//   channel  handshake              payload
//   item     item_valid/item_stall  now_ms, available_kbps, backlog
//   result   result_valid/result_stall  transmit_level
//   config   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled; the result is
// presented from the result register, which its item reaches through the input register.
// The state update (EWMA, level, timers) runs combinationally on the registered
// item, between the input register and the result register.
// Synchronous active-high reset; no clearing pass, ready after reset.
// A stalled result holds; the input register keeps taking items until it
// is full and the result is still stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module link_rate_mode_selector_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  output      logic                             item_stall,
  input  wire logic [lrms_pkg::TIME_W-1:0]      now_ms,
  input  wire logic signed [lrms_pkg::KBPS_W-1:0] available_kbps,
  input  wire logic [lrms_pkg::DEPTH_W-1:0]     backlog,
  output      logic                             result_valid,
  input  wire logic                             result_stall,
  output      logic [lrms_pkg::LEVEL_W-1:0]     transmit_level,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [lrms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lrms_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lrms_pkg::cfg_t               cfg;
  lrms_pkg::rate_info_t         info;

  logic                         stage_valid;
  logic [lrms_pkg::TIME_W-1:0]  stage_now;
  logic [lrms_pkg::RATE_W-1:0]  stage_rate;
  logic [lrms_pkg::DEPTH_W-1:0] stage_depth;
  logic [lrms_pkg::LEVEL_W-1:0] level_next;
  logic                         out_free;
  logic                         advance;
  logic                         accept;

  assign out_free   = !result_valid || !result_stall;
  assign advance    = stage_valid && out_free;
  assign item_stall = stage_valid && !out_free;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_now   <= now_ms;
      stage_rate  <= available_kbps[lrms_pkg::KBPS_W-1] ? '0
                   : available_kbps[lrms_pkg::RATE_W-1:0];
      stage_depth <= backlog;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      transmit_level <= level_next;
    end
  end

  lrms_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lrms_rate_filter u_rate_filter (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .x    (stage_rate),
    .info (info)
  );

  lrms_level_ctrl u_level_ctrl (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .now        (stage_now),
    .depth      (stage_depth),
    .info       (info),
    .cfg        (cfg),
    .level_next (level_next)
  );

endmodule

`default_nettype wire

FILE: hdl/lrms_checker.sv
// ----------------------------------------------------------------------------
// lrms_checker
// Port-level checks of the rate mode selector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "link_rate_mode_selector_unit_defines.svh"

module lrms_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_stall,
  input  wire logic                             result_valid,
  input  wire logic                             result_stall,
  input  wire logic [lrms_pkg::LEVEL_W-1:0]     transmit_level
);

  // input side backs up only behind a stalled result
  `LRMS_ASSERT_IMP(a_stall_only_when_full, item_stall, result_valid && result_stall, "item stalled while result side free")

  // a stalled result transaction holds its level
  `LRMS_ASSERT_NXT(a_result_holds, result_valid && result_stall, result_valid && $stable(transmit_level), "stalled result changed")

  // nothing is presented right after reset
  `LRMS_ASSERT_IMP(a_empty_after_reset, $past(rst), !result_valid && !item_stall, "pipeline not empty after reset")

endmodule

bind link_rate_mode_selector_unit lrms_checker u_lrms_checker (.*);

`default_nettype wire
